@@ sv/assert_macros.svh @@
// assertion macros used by the clamp unit top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define VMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define VMC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMC_ASSERT(lbl, prop, msg)
`define VMC_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

@@ sv/vmc_pkg.sv @@
// shared widths, pipeline types and helpers of the vector magnitude clamp
// no dependencies
package vmc_pkg;

  localparam int COMP_W     = 24;
  localparam int MAXM_W     = 23;
  localparam int SQ_W       = 47;
  localparam int SUM_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 26;
  localparam int PROD_W     = 47;
  localparam int QUO_W      = 23;
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 23;

  localparam logic [MAXM_W-1:0] MAXM_RESET = 23'd65536;

  // control and original data travelling with an item
  typedef struct packed {
    logic                         vld;
    logic                         invalid;
    logic                         over;
    logic [2:0][COMP_W-1:0]       comp;
  } vmc_ctl_t;

  // square root working set: radicand shifts out two bits per cell
  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } vmc_sqrt_t;

  // divider working set: dividend low bits shift out as quotient bits shift in
  typedef struct packed {
    logic [ROOT_W-1:0]            len;
    logic [2:0][ROOT_W-1:0]       rem;
    logic [2:0][QUO_W-1:0]        dq;
  } vmc_div_t;

  // magnitude of a signed component, 2^23 included
  function automatic logic [COMP_W-1:0] vmc_abs(input logic [COMP_W-1:0] c);
    vmc_abs = c[COMP_W-1] ? (~c + 1'b1) : c;
  endfunction

endpackage

@@ sv/vmc_ifs.sv @@
// handshake channels of the vector magnitude clamp unit
// depends on vmc_pkg
interface vmc_in_if;
  import vmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] x_in;
  logic signed [COMP_W-1:0] y_in;
  logic signed [COMP_W-1:0] z_in;
  logic                     invalid;
  modport source (output valid, x_in, y_in, z_in, invalid, input ready);
  modport sink (input valid, x_in, y_in, z_in, invalid, output ready);
endinterface

interface vmc_out_if;
  import vmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] x_out;
  logic signed [COMP_W-1:0] y_out;
  logic signed [COMP_W-1:0] z_out;
  logic                     was_clamped;
  logic                     was_zeroed;
  modport source (output valid, x_out, y_out, z_out, was_clamped, was_zeroed,
                  input ready);
  modport sink (input valid, x_out, y_out, z_out, was_clamped, was_zeroed,
                output ready);
endinterface

interface vmc_cfg_if;
  import vmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MAXM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/vector_magnitude_clamp_unit.sv @@
// top level of the vector magnitude clamp: squares, sum, sqrt and divide chains
// depends on vmc_pkg, vmc_ifs, vmc_sqrt_cell, vmc_div_cell, assert_macros.svh
//
//   channel   dir  payload                                  accepted when
//   in_ch     in   x_in, y_in, z_in, invalid                valid && ready
//   out_ch    out  x_out, y_out, z_out, was_clamped/zeroed  valid && ready
//   cfg_ch    in   data (max_magnitude, 23 bits)            valid && ready
//
// one item per cycle while the output is not stalled; the pipeline is the 24 square root cells
// and the 23 divider cells plus six register stages
// the whole pipeline moves together; it halts only while a result waits
// in the output register and the sink is not ready
// reset is synchronous and clears the valid bits and max_magnitude to 1.0
`include "assert_macros.svh"

module vector_magnitude_clamp_unit (
  input logic       clk,
  input logic       rst_n,
  vmc_in_if.sink    in_ch,
  vmc_out_if.source out_ch,
  vmc_cfg_if.sink   cfg_ch
);
  import vmc_pkg::*;

  logic                   adv;
  logic [MAXM_W-1:0]      max_r;
  logic [2*MAXM_W-1:0]    m2_r;

  vmc_ctl_t               ctl0_r;
  vmc_ctl_t               ctl1_r;
  vmc_ctl_t               ctl2_r;
  logic [2:0][SQ_W-1:0]   sq1_r;
  logic [SUM_W-1:0]       s2_r;
  logic [2:0][2*COMP_W-1:0] sq_full;

  vmc_ctl_t               ctl_sq [0:SQRT_STEPS];
  vmc_sqrt_t              st_sq  [0:SQRT_STEPS];
  vmc_ctl_t               ctl3_r;
  vmc_sqrt_t              sq3_r;

  vmc_ctl_t               ctl_dv [0:DIV_STEPS];
  vmc_div_t               st_dv  [0:DIV_STEPS];
  vmc_ctl_t               ctlp_r;
  vmc_div_t               dvp_r;
  logic [2:0][COMP_W+MAXM_W-1:0] prod;

  logic                   out_vld_r;
  logic [2:0][COMP_W-1:0] res_nxt;
  logic [2:0][COMP_W-1:0] res_r;
  logic                   clamped_r;
  logic                   zeroed_r;
  logic [QUO_W-1:0]       qs;
  logic [COMP_W-1:0]      qe;
  vmc_ctl_t               ctl_last;

  // pipeline advances unless a result is stuck at the output
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  // configuration register and its square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAXM_RESET;
    end else if (cfg_ch.valid) begin
      max_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    m2_r <= (2*MAXM_W)'(max_r) * (2*MAXM_W)'(max_r);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.vld <= 1'b0;
    end else if (adv) begin
      ctl0_r.vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl0_r.invalid <= in_ch.invalid;
      ctl0_r.over    <= 1'b0;
      ctl0_r.comp    <= {in_ch.z_in, in_ch.y_in, in_ch.x_in};
    end
  end

  // squares of the component magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = (2*COMP_W)'(vmc_abs(ctl0_r.comp[i])) *
                   (2*COMP_W)'(vmc_abs(ctl0_r.comp[i]));
    end
  end

  // stages: squares, sum, compare against max squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
    end else if (adv) begin
      ctl1_r.vld <= ctl0_r.vld;
      ctl2_r.vld <= ctl1_r.vld;
      ctl3_r.vld <= ctl2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= sq_full[i][SQ_W-1:0];
      end
      ctl1_r.invalid <= ctl0_r.invalid;
      ctl1_r.over    <= 1'b0;
      ctl1_r.comp    <= ctl0_r.comp;

      s2_r <= {1'b0, sq1_r[0]} + {1'b0, sq1_r[1]} + {1'b0, sq1_r[2]};
      ctl2_r.invalid <= ctl1_r.invalid;
      ctl2_r.over    <= 1'b0;
      ctl2_r.comp    <= ctl1_r.comp;

      sq3_r.rad      <= s2_r;
      sq3_r.rem      <= '0;
      sq3_r.root     <= '0;
      ctl3_r.invalid <= ctl2_r.invalid;
      ctl3_r.over    <= (s2_r > {{(SUM_W-2*MAXM_W){1'b0}}, m2_r});
      ctl3_r.comp    <= ctl2_r.comp;
    end
  end

  // square root chain
  assign ctl_sq[0] = ctl3_r;
  assign st_sq[0]  = sq3_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    vmc_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_sq[g]),
      .sq_i  (st_sq[g]),
      .ctl_o (ctl_sq[g+1]),
      .sq_o  (st_sq[g+1])
    );
  end

  // scaled magnitudes ahead of the divider
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (COMP_W+MAXM_W)'(vmc_abs(ctl_sq[SQRT_STEPS].comp[i])) *
                (COMP_W+MAXM_W)'(max_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlp_r.vld <= 1'b0;
    end else if (adv) begin
      ctlp_r.vld <= ctl_sq[SQRT_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctlp_r.invalid <= ctl_sq[SQRT_STEPS].invalid;
      ctlp_r.over    <= ctl_sq[SQRT_STEPS].over;
      ctlp_r.comp    <= ctl_sq[SQRT_STEPS].comp;
      dvp_r.len      <= st_sq[SQRT_STEPS].root;
      for (int i = 0; i < 3; i++) begin
        dvp_r.rem[i] <= prod[i][PROD_W-1:QUO_W];
        dvp_r.dq[i]  <= prod[i][QUO_W-1:0];
      end
    end
  end

  // divider chain
  assign ctl_dv[0] = ctlp_r;
  assign st_dv[0]  = dvp_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    vmc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_dv[g]),
      .dv_i  (st_dv[g]),
      .ctl_o (ctl_dv[g+1]),
      .dv_o  (st_dv[g+1])
    );
  end

  // saturate, restore sign, pick pass, rescale or zero
  assign ctl_last = ctl_dv[DIV_STEPS];

  always_comb begin
    qs = '0;
    qe = '0;
    for (int i = 0; i < 3; i++) begin
      qs = (st_dv[DIV_STEPS].dq[i] > max_r) ? max_r : st_dv[DIV_STEPS].dq[i];
      qe = {1'b0, qs};
      if (ctl_last.invalid) begin
        res_nxt[i] = '0;
      end else if (ctl_last.over) begin
        res_nxt[i] = ctl_last.comp[i][COMP_W-1] ? (~qe + 1'b1) : qe;
      end else begin
        res_nxt[i] = ctl_last.comp[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= ctl_last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r     <= res_nxt;
      clamped_r <= !ctl_last.invalid && ctl_last.over;
      zeroed_r  <= ctl_last.invalid;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.x_out       = res_r[0];
  assign out_ch.y_out       = res_r[1];
  assign out_ch.z_out       = res_r[2];
  assign out_ch.was_clamped = clamped_r;
  assign out_ch.was_zeroed  = zeroed_r;

  // checks
  `VMC_ASSERT(a_flags_excl, out_ch.valid |-> !(out_ch.was_clamped && out_ch.was_zeroed), "clamped and zeroed together")
  `VMC_ASSERT(a_zero_vec, (out_ch.valid && out_ch.was_zeroed) |-> ((out_ch.x_out == '0) && (out_ch.y_out == '0) && (out_ch.z_out == '0)), "zeroed item not zero")
  `VMC_ASSERT(a_stall_in, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready, "input taken during output stall")
  `VMC_ASSERT_ANY(a_rst_clear, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule

@@ sv/vmc_sqrt_cell.sv @@
// one cell of the square root chain: one root bit per cell
// depends on vmc_pkg
module vmc_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  vmc_pkg::vmc_ctl_t  ctl_i,
  input  vmc_pkg::vmc_sqrt_t sq_i,
  output vmc_pkg::vmc_ctl_t  ctl_o,
  output vmc_pkg::vmc_sqrt_t sq_o
);
  import vmc_pkg::*;

  vmc_ctl_t           ctl_r;
  vmc_sqrt_t          sq_r;
  vmc_sqrt_t          sq_nxt;
  logic [REM_W+1:0]   cur;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;
  logic               ge;

  // trial subtract of 4*root+1 from the remainder with two new bits
  always_comb begin
    cur         = {sq_i.rem, sq_i.rad[SUM_W-1 -: 2]};
    trial       = {2'b00, sq_i.root, 2'b01};
    diff        = cur - trial;
    ge          = (cur >= trial);
    sq_nxt.rad  = {sq_i.rad[SUM_W-3:0], 2'b00};
    sq_nxt.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    sq_nxt.root = {sq_i.root[ROOT_W-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r.vld <= ctl_i.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r.invalid <= ctl_i.invalid;
      ctl_r.over    <= ctl_i.over;
      ctl_r.comp    <= ctl_i.comp;
      sq_r          <= sq_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign sq_o  = sq_r;

endmodule

@@ sv/vmc_div_cell.sv @@
// one cell of the divider chain: one quotient bit for all three lanes
// depends on vmc_pkg
module vmc_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  vmc_pkg::vmc_ctl_t ctl_i,
  input  vmc_pkg::vmc_div_t dv_i,
  output vmc_pkg::vmc_ctl_t ctl_o,
  output vmc_pkg::vmc_div_t dv_o
);
  import vmc_pkg::*;

  vmc_ctl_t          ctl_r;
  vmc_div_t          dv_r;
  vmc_div_t          dv_nxt;
  logic [ROOT_W:0]   t;
  logic [ROOT_W:0]   d;
  logic              ge;

  // restoring step per lane, the lanes are independent
  always_comb begin
    dv_nxt.len = dv_i.len;
    dv_nxt.rem = dv_i.rem;
    dv_nxt.dq  = dv_i.dq;
    t          = '0;
    d          = '0;
    ge         = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t             = {dv_i.rem[i], dv_i.dq[i][QUO_W-1]};
      d             = t - {1'b0, dv_i.len};
      ge            = (t >= {1'b0, dv_i.len});
      dv_nxt.rem[i] = ge ? d[ROOT_W-1:0] : t[ROOT_W-1:0];
      dv_nxt.dq[i]  = {dv_i.dq[i][QUO_W-2:0], ge};
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r.vld <= ctl_i.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r.invalid <= ctl_i.invalid;
      ctl_r.over    <= ctl_i.over;
      ctl_r.comp    <= ctl_i.comp;
      dv_r          <= dv_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign dv_o  = dv_r;

endmodule
